// File: rtl/core/lcdtp_pkg.sv
// Shared types, constants and the init command table for the character display
// text placement block. Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps

package lcdtp_pkg;

  // Default geometry and queue size.
  localparam int LINE_LEN_DEFAULT    = 20;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Display command bytes of the init sequence.
  localparam logic [7:0] CMD_FUNCTION_SET  = 8'h38;
  localparam logic [7:0] CMD_DISPLAY_BLINK = 8'h0F;
  localparam logic [7:0] CMD_CLEAR         = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE    = 8'h06;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_RETURN     = 8'h0D;
  localparam logic [7:0] CH_RESET_PREV = 8'h61;

  // Reset values of the configuration registers.
  localparam logic [7:0] LINE_TWO_RESET    = 8'hC0;
  localparam logic [7:0] LINE_THREE_RESET  = 8'h94;
  localparam logic [7:0] LINE_FOUR_RESET   = 8'hD4;
  localparam logic [7:0] CLEAR_AFTER_RESET = 8'h3B;
  localparam logic [7:0] CLEAR_KEY_RESET   = 8'h2E;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 3;
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LINE_TWO    = 3'd0,
    REG_LINE_THREE  = 3'd1,
    REG_LINE_FOUR   = 3'd2,
    REG_CLEAR_AFTER = 3'd3,
    REG_CLEAR_KEY   = 3'd4
  } cfg_reg_t;

  // Character source codes.
  localparam logic SRC_LINK   = 1'b0;
  localparam logic SRC_KEYPAD = 1'b1;

  // Segments of one item's write plan, in emission order.
  localparam int SEG_W    = 5;
  localparam int SEG_PRE  = 0;  // forced re-init before a link character
  localparam int SEG_DATA = 1;  // the character data write
  localparam int SEG_ADDR = 2;  // set-address for the next line
  localparam int SEG_MID  = 3;  // re-init after the fourth line filled
  localparam int SEG_POST = 4;  // re-init after the keypad clear key
  localparam logic [SEG_W-1:0] SEG_INIT_MASK = 5'b11001;

  localparam logic [1:0] INIT_STEP_LAST = 2'd3;

  typedef struct packed {
    logic [7:0] line_two_addr;
    logic [7:0] line_three_addr;
    logic [7:0] line_four_addr;
    logic [7:0] clear_after;
    logic [7:0] clear_key;
  } cfg_t;

  typedef struct packed {
    logic [SEG_W-1:0] seg;
    logic [7:0]       data;
    logic             uplink;
    logic [7:0]       addr;
  } plan_t;

  // Init command for each step of the re-init sequence.
  function automatic logic [7:0] init_cmd(input logic [1:0] step);
    logic [7:0] cmd;
    case (step)
      2'd0:    cmd = CMD_FUNCTION_SET;
      2'd1:    cmd = CMD_DISPLAY_BLINK;
      2'd2:    cmd = CMD_CLEAR;
      default: cmd = CMD_ENTRY_MODE;
    endcase
    return cmd;
  endfunction

endpackage

// File: rtl/core/lcdtp_front.sv
// Front end: accepts characters, tracks cursor line, column and last link
// character, and turns each character into a write plan. Uses lcdtp_pkg.
`timescale 1ns / 1ps

module lcdtp_front #(
  parameter int LINE_LEN = lcdtp_pkg::LINE_LEN_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  lcdtp_pkg::cfg_t    cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [7:0]         in_char,
  output logic               plan_valid,
  output lcdtp_pkg::plan_t   plan,
  input  logic               plan_ready
);

  localparam int COL_W = $clog2(LINE_LEN + 1);

  logic [1:0]       line;
  logic [COL_W-1:0] col;
  logic [7:0]       prev;

  logic [1:0]       line_next;
  logic [COL_W-1:0] col_next;
  logic [7:0]       prev_next;

  logic             accept;
  logic             is_link;
  logic             pre;
  logic [1:0]       line0;
  logic [COL_W-1:0] col0;
  logic             drop;
  logic [COL_W-1:0] col_inc;
  logic             new_line;
  logic [2:0]       line_inc;
  logic             mid;
  logic             addr_en;
  logic             post;
  logic [7:0]       addr;

  // Classify the character and work out the cursor after it.
  always_comb begin
    accept   = in_valid && plan_ready;
    is_link  = (in_action == lcdtp_pkg::SRC_LINK);
    pre      = is_link && (prev == cfg.clear_after);
    line0    = pre ? 2'd0 : line;
    col0     = pre ? '0 : col;
    drop     = (col0 == '0) && (in_char == lcdtp_pkg::CH_SPACE);
    col_inc  = col0 + COL_W'(1);
    new_line = !drop && ((col_inc == COL_W'(LINE_LEN)) || (in_char == lcdtp_pkg::CH_RETURN));
    line_inc = {1'b0, line0} + 3'd1;
    mid      = new_line && (line_inc == 3'd4);
    addr_en  = new_line && !mid;
    post     = !is_link && (in_char == cfg.clear_key);

    case (line_inc[1:0])
      2'd1:    addr = cfg.line_two_addr;
      2'd2:    addr = cfg.line_three_addr;
      default: addr = cfg.line_four_addr;
    endcase

    line_next = line0;
    col_next  = col0;
    prev_next = is_link ? in_char : prev;
    if (!drop) begin
      if (new_line) begin
        col_next  = '0;
        line_next = line_inc[1:0];
      end else begin
        col_next = col_inc;
      end
    end
    if (mid || post) begin
      line_next = 2'd0;
      col_next  = '0;
      prev_next = lcdtp_pkg::CH_RESET_PREV;
    end
  end

  // Build the plan; an item that writes nothing is not queued.
  always_comb begin
    plan.seg                      = '0;
    plan.seg[lcdtp_pkg::SEG_PRE]  = pre;
    plan.seg[lcdtp_pkg::SEG_DATA] = !drop;
    plan.seg[lcdtp_pkg::SEG_ADDR] = addr_en;
    plan.seg[lcdtp_pkg::SEG_MID]  = mid;
    plan.seg[lcdtp_pkg::SEG_POST] = post;
    plan.data                     = in_char;
    plan.uplink                   = !is_link;
    plan.addr                     = addr;
    plan_valid                    = accept && (plan.seg != '0);
  end

  assign in_ready = plan_ready;

  // Cursor and last received link character.
  always_ff @(posedge clk) begin
    if (rst) begin
      line <= 2'd0;
      col  <= '0;
      prev <= lcdtp_pkg::CH_RESET_PREV;
    end else if (accept) begin
      line <= line_next;
      col  <= col_next;
      prev <= prev_next;
    end
  end

  // The column never reaches the line length.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col < COL_W'(LINE_LEN))
    else $error("column out of range");

  // A keypad clear key leaves the cursor at home and the history cleared.
  a_key_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_link && (in_char == cfg.clear_key)) |=>
      (line == 2'd0 && col == '0 && prev == lcdtp_pkg::CH_RESET_PREV))
    else $error("keypad clear did not reset the cursor");

endmodule

// File: rtl/core/lcdtp_queue.sv
// Short plan queue between the front and back ends of the placement block.
// Uses lcdtp_pkg for the plan type.
`timescale 1ns / 1ps

module lcdtp_queue #(
  parameter int DEPTH = lcdtp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lcdtp_pkg::plan_t push_plan,
  output logic             push_ready,
  input  logic             pop,
  output logic             head_valid,
  output lcdtp_pkg::plan_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lcdtp_pkg::plan_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] rd_ptr_next;

  assign push_ready  = (count != CNT_W'(DEPTH));
  assign head_valid  = (count != '0);
  assign rd_ptr_next = pop ? ((rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1))
                           : rd_ptr;

  // Storage write and registered head read; a plan pushed to the next read
  // address is forwarded straight into the head register.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_plan;
    end
    if (push && (wr_ptr == rd_ptr_next)) begin
      head <= push_plan;
    end else begin
      head <= mem[rd_ptr_next];
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      rd_ptr <= rd_ptr_next;
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // The fill count stays within the depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

// File: rtl/core/lcdtp_back.sv
// Back end: walks the head plan segment by segment and issues one display write
// word per cycle into an output register unless m_ready stalls. Uses lcdtp_pkg.
`timescale 1ns / 1ps

module lcdtp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  lcdtp_pkg::plan_t head,
  output logic             pop,
  output logic             m_valid,
  input  logic             m_ready,
  output logic [7:0]       m_data,
  output logic [1:0]       m_user,
  output logic             m_last
);

  localparam int SW = lcdtp_pkg::SEG_W;

  logic [SW-1:0] done;
  logic [1:0]    sub;

  logic [SW-1:0] live;
  logic [SW-1:0] cur;
  logic [SW-1:0] rest;
  logic          seg_end;
  logic          last;
  logic          fire;
  logic          word_is_data;
  logic          word_uplink;
  logic [7:0]    word_byte;

  // Pick the current segment and form its word.
  always_comb begin
    live    = head.seg & ~done;
    cur     = live & (~live + SW'(1));
    rest    = live & ~cur;
    seg_end = ((cur & lcdtp_pkg::SEG_INIT_MASK) == '0) || (sub == lcdtp_pkg::INIT_STEP_LAST);
    last    = seg_end && (rest == '0);
    fire    = head_valid && (!m_valid || m_ready);
    pop     = fire && last;

    if (cur[lcdtp_pkg::SEG_DATA]) begin
      word_is_data = 1'b1;
      word_uplink  = head.uplink;
      word_byte    = head.data;
    end else if (cur[lcdtp_pkg::SEG_ADDR]) begin
      word_is_data = 1'b0;
      word_uplink  = 1'b0;
      word_byte    = head.addr;
    end else begin
      word_is_data = 1'b0;
      word_uplink  = 1'b0;
      word_byte    = lcdtp_pkg::init_cmd(sub);
    end
  end

  // Segment progress and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done    <= '0;
      sub     <= 2'd0;
      m_valid <= 1'b0;
    end else begin
      if (fire) begin
        m_valid <= 1'b1;
        if (last) begin
          done <= '0;
          sub  <= 2'd0;
        end else if (seg_end) begin
          done <= done | cur;
          sub  <= 2'd0;
        end else begin
          sub <= sub + 2'd1;
        end
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_data <= word_byte;
      m_user <= {word_uplink, word_is_data};
      m_last <= last;
    end
  end

  // A queued plan always has a segment left to issue.
  a_live_seg: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (live != '0))
    else $error("head plan has no segment left");

  // A re-init walk in progress keeps its plan at the head.
  a_sub_held: assert property (@(posedge clk) disable iff (rst)
    (sub != 2'd0) |-> (head_valid && ((cur & lcdtp_pkg::SEG_INIT_MASK) != '0)))
    else $error("init step count without an init segment");

endmodule

// File: rtl/core/char_lcd_text_placement.sv
// Top level of the character display text placement block: configuration
// registers, front end, plan queue and back end. Uses lcdtp_pkg and rtl/core modules.
`timescale 1ns / 1ps

// Takes one character per input word (tuser selects link or keypad) and
// produces the display write words it causes: zero to nine per character,
// each marked data or command, with tlast on the final word of a character.
// The front end takes a new character every cycle as long as the plan queue
// (QUEUE_DEPTH entries) has room; the back end issues one display word per
// cycle while it has words pending and m_axis_tready does not stall it.
// Configuration must be written through cfg_we, cfg_addr and cfg_wdata only
// while no character is in flight; the block does not enforce this.

module char_lcd_text_placement #(
  parameter int LINE_LEN    = lcdtp_pkg::LINE_LEN_DEFAULT,
  parameter int QUEUE_DEPTH = lcdtp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lcdtp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [7:0]                     cfg_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] char_byte
  input  logic                           s_axis_tuser,  // [0] action
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [7:0] lcd_byte
  output logic [1:0]                     m_axis_tuser,  // [0] lcd_is_data, [1] uplink_send
  output logic                           m_axis_tlast
);

  lcdtp_pkg::cfg_t  cfg;
  lcdtp_pkg::plan_t plan;
  lcdtp_pkg::plan_t head;
  logic             plan_valid;
  logic             plan_ready;
  logic             head_valid;
  logic             pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_two_addr   <= lcdtp_pkg::LINE_TWO_RESET;
      cfg.line_three_addr <= lcdtp_pkg::LINE_THREE_RESET;
      cfg.line_four_addr  <= lcdtp_pkg::LINE_FOUR_RESET;
      cfg.clear_after     <= lcdtp_pkg::CLEAR_AFTER_RESET;
      cfg.clear_key       <= lcdtp_pkg::CLEAR_KEY_RESET;
    end else if (cfg_we) begin
      case (lcdtp_pkg::cfg_reg_t'(cfg_addr))
        lcdtp_pkg::REG_LINE_TWO:    cfg.line_two_addr   <= cfg_wdata;
        lcdtp_pkg::REG_LINE_THREE:  cfg.line_three_addr <= cfg_wdata;
        lcdtp_pkg::REG_LINE_FOUR:   cfg.line_four_addr  <= cfg_wdata;
        lcdtp_pkg::REG_CLEAR_AFTER: cfg.clear_after     <= cfg_wdata;
        lcdtp_pkg::REG_CLEAR_KEY:   cfg.clear_key       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Character classification and cursor tracking.
  lcdtp_front #(
    .LINE_LEN (LINE_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_action  (s_axis_tuser),
    .in_char    (s_axis_tdata),
    .plan_valid (plan_valid),
    .plan       (plan),
    .plan_ready (plan_ready)
  );

  // Plans waiting for the back end.
  lcdtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (plan_valid),
    .push_plan  (plan),
    .push_ready (plan_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Display write word generation.
  lcdtp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_valid    (m_axis_tvalid),
    .m_ready    (m_axis_tready),
    .m_data     (m_axis_tdata),
    .m_user     (m_axis_tuser),
    .m_last     (m_axis_tlast)
  );

endmodule
